@@ rtl/gap_framed_clocked_bit_capture_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef GAP_FRAMED_CLOCKED_BIT_CAPTURE_CORE_DEFINES_SVH
`define GAP_FRAMED_CLOCKED_BIT_CAPTURE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define GFBC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GFBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles.
`define GFBC_ASSERT_DELAY(lbl, ante, n, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

@@ rtl/gfbc_pkg.sv @@
package gfbc_pkg;

   // bit buffer geometry
   localparam int POS_W       = 12;
   localparam int BUFFER_BITS = 2 ** POS_W;
   localparam int WORD_LSB    = 5;
   localparam int WORD_BITS   = 2 ** WORD_LSB;
   localparam int WORDS       = BUFFER_BITS / WORD_BITS;
   localparam int WADDR_W     = POS_W - WORD_LSB;

   // commands
   localparam logic [1:0] CMD_EDGE  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // sampler modes
   localparam logic [2:0] MODE_STATS      = 3'd0;
   localparam logic [2:0] MODE_GAP_COUNT  = 3'd1;
   localparam logic [2:0] MODE_RESTART    = 3'd2;
   localparam logic [2:0] MODE_GAP_WAIT   = 3'd3;
   localparam logic [2:0] MODE_GAP_FINISH = 3'd4;

   // phases
   localparam logic [1:0] PH_SEEK    = 2'd0;
   localparam logic [1:0] PH_CAPTURE = 2'd1;
   localparam logic [1:0] PH_DONE    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_GAP    = 2'd1;
   localparam logic [1:0] CSR_WANTED = 2'd2;

   localparam logic [2:0]  MODE_RESET = MODE_GAP_WAIT;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_FETCH2,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [31:0]      time_stamp;
      logic             data_bit;
      logic [POS_W-1:0] slice_from;
      logic [POS_W-1:0] slice_to;
      logic             sign_extend;
   } req_type;

   typedef struct packed {
      logic [31:0]      slice_value;
      logic             slice_error;
      logic [1:0]       phase;
      logic [POS_W-1:0] bit_position;
      logic [31:0]      misfire_count;
      logic [31:0]      restart_count;
      logic [31:0]      min_period;
      logic [31:0]      max_period;
      logic [15:0]      sampled_count;
   } rsp_type;

endpackage

@@ rtl/gap_framed_clocked_bit_capture_core.sv @@
// Gap-framed clocked bit capture. Each item on the req_ channel is a clock
// edge (with its time stamp and data bit), a start/arm command or a read of
// up to 32 captured bits; every item returns exactly one item on rsp_ that
// carries the slice (zero unless a read) and a snapshot of the capture state
// after the item. Captured bits live in a 128 x 32 word memory with one read
// and one write port. Edge and start items pass accept (item and period
// registered), gap test and word read, then read-modify-write; reads add a
// second word fetch, since the slice may straddle two words and the memory
// gives one word per cycle. The block holds one item at a time, but accepts
// the next item while an earlier result still waits on rsp_ready. After reset
// it zeroes all 128 words of the bit memory, one word per cycle, with
// req_ready low. The user must write csr_ only while idle; the block does not enforce it.
module gap_framed_clocked_bit_capture_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gfbc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gfbc_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   localparam int POS_W   = gfbc_pkg::POS_W;
   localparam int WADDR_W = gfbc_pkg::WADDR_W;
   localparam int LSB     = gfbc_pkg::WORD_LSB;

   // sequencer
   gfbc_pkg::state_type state_ff, state_in;
   logic [WADDR_W-1:0]  clr_ff;

   // configuration
   logic [2:0]  mode_ff;
   logic [31:0] gap_period_ff;
   logic [12:0] bits_wanted_ff;

   // capture state
   logic [POS_W-1:0] wp_ff, wp_in;
   logic [1:0]       phase_ff, phase_in;
   logic [31:0]      last_ff, last_in;
   logic [31:0]      min_ff, min_in;
   logic [31:0]      max_ff, max_in;
   logic [31:0]      misfire_ff, misfire_in;
   logic [31:0]      restart_ff, restart_in;
   logic [15:0]      sampled_ff, sampled_in;

   // item in flight
   gfbc_pkg::req_type item_ff;
   logic [31:0]      period_ff;
   logic             gap_ff;
   logic             store_zero_ff;
   logic             slice_err_ff;
   logic [4:0]       span_ff;
   logic [31:0]      word0_ff;

   // output slot
   logic              rsp_valid_ff;
   gfbc_pkg::rsp_type rsp_ff, rsp_in;

   // memory port
   logic               mem_we, mem_re;
   logic [WADDR_W-1:0] mem_waddr, mem_raddr;
   logic [31:0]        mem_wdata, mem_rdata;

   logic accept, out_free, commit;
   logic gap_now, store_zero_now;
   logic [POS_W-1:0] hi_pos, wp_m1, slice_diff;
   logic slice_err_now;
   logic store_en;
   logic [POS_W-1:0] store_pos;
   logic [31:0] store_word;
   logic [63:0] dword;
   logic [31:0] raw, mask, slice_val;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == gfbc_pkg::ST_EXEC) && out_free;

   // ---- gap test and slice bounds, evaluated in ST_CALC ----
   assign gap_now = period_ff > gap_period_ff;
   // these modes restart the capture at position zero on a gap
   assign store_zero_now = gap_now &&
      (mode_ff == gfbc_pkg::MODE_RESTART ||
       (mode_ff == gfbc_pkg::MODE_GAP_WAIT && phase_ff != gfbc_pkg::PH_SEEK) ||
       mode_ff == gfbc_pkg::MODE_GAP_FINISH);

   // slice_to clamps to the last written bit; nothing written is an error
   assign wp_m1      = wp_ff - 1'b1;
   assign hi_pos     = (item_ff.slice_to >= wp_ff) ? wp_m1 : item_ff.slice_to;
   assign slice_diff = hi_pos - item_ff.slice_from;
   assign slice_err_now = (wp_ff == '0) || (item_ff.slice_from > hi_pos) ||
                          (slice_diff > POS_W'(31));

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gfbc_pkg::ST_CLEAR: begin
            if (clr_ff == WADDR_W'(gfbc_pkg::WORDS - 1)) begin
               state_in = gfbc_pkg::ST_IDLE;
            end
         end
         gfbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = gfbc_pkg::ST_CALC;
            end
         end
         gfbc_pkg::ST_CALC: begin
            state_in = (item_ff.command == gfbc_pkg::CMD_READ) ?
                       gfbc_pkg::ST_FETCH2 : gfbc_pkg::ST_EXEC;
         end
         gfbc_pkg::ST_FETCH2: begin
            state_in = gfbc_pkg::ST_EXEC;
         end
         gfbc_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = gfbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gfbc_pkg::ST_CLEAR;
         end
      endcase
   end

   // ---- sequencer outputs: handshake and memory port ----
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = store_pos[POS_W-1:LSB];
      mem_wdata = store_word;
      mem_re    = 1'b0;
      mem_raddr = item_ff.slice_from[POS_W-1:LSB];
      unique case (state_ff)
         gfbc_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         gfbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         gfbc_pkg::ST_CALC: begin
            // edge: fetch the word the bit lands in; read: first slice word
            mem_re = 1'b1;
            if (item_ff.command != gfbc_pkg::CMD_READ) begin
               mem_raddr = store_zero_now ? '0 : wp_ff[POS_W-1:LSB];
            end
         end
         gfbc_pkg::ST_FETCH2: begin
            mem_re    = 1'b1;
            mem_raddr = item_ff.slice_from[POS_W-1:LSB] + 1'b1;
         end
         gfbc_pkg::ST_EXEC: begin
            mem_we = commit && store_en;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---- item execution, applied on commit ----
   always_comb begin
      wp_in      = wp_ff;
      phase_in   = phase_ff;
      last_in    = last_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      misfire_in = misfire_ff;
      restart_in = restart_ff;
      sampled_in = sampled_ff;
      store_en   = 1'b0;
      store_pos  = store_zero_ff ? '0 : wp_ff;

      unique case (item_ff.command)
         gfbc_pkg::CMD_EDGE: begin
            if (mode_ff == gfbc_pkg::MODE_STATS) begin
               if (period_ff < min_ff) min_in = period_ff;
               if (period_ff > max_ff) max_in = period_ff;
               last_in = item_ff.time_stamp;
            end else if (mode_ff > gfbc_pkg::MODE_GAP_FINISH) begin
               // unused modes ignore edges
               last_in = last_ff;
            end else if (phase_ff == gfbc_pkg::PH_DONE) begin
               misfire_in = misfire_ff + 1'b1;
            end else begin
               last_in = item_ff.time_stamp;
               unique case (mode_ff)
                  gfbc_pkg::MODE_GAP_COUNT: begin
                     if (phase_ff == gfbc_pkg::PH_SEEK) begin
                        if (gap_ff) begin
                           phase_in = gfbc_pkg::PH_CAPTURE;
                           wp_in    = wp_ff + 1'b1;
                        end
                     end else if (gap_ff) begin
                        // second gap closes the count, time stays
                        phase_in = gfbc_pkg::PH_DONE;
                        last_in  = last_ff;
                     end else begin
                        wp_in = wp_ff + 1'b1;
                     end
                  end
                  gfbc_pkg::MODE_RESTART: begin
                     store_en = 1'b1;
                     wp_in    = store_pos + 1'b1;
                     if (gap_ff) begin
                        restart_in = restart_ff + 1'b1;
                     end else if ({1'b0, wp_in} >= bits_wanted_ff) begin
                        phase_in = gfbc_pkg::PH_DONE;
                     end
                  end
                  gfbc_pkg::MODE_GAP_WAIT: begin
                     if (phase_ff == gfbc_pkg::PH_SEEK) begin
                        if (gap_ff) begin
                           phase_in = gfbc_pkg::PH_CAPTURE;
                           store_en = 1'b1;
                           wp_in    = store_pos + 1'b1;
                        end
                     end else begin
                        store_en = 1'b1;
                        wp_in    = store_pos + 1'b1;
                        if (gap_ff) begin
                           restart_in = restart_ff + 1'b1;
                        end else if ({1'b0, wp_in} >= bits_wanted_ff) begin
                           phase_in = gfbc_pkg::PH_DONE;
                        end
                     end
                  end
                  default: begin
                     // gap-finish: a gap ends the frame once enough bits are in
                     if (gap_ff && ({3'b000, bits_wanted_ff} <= sampled_ff)) begin
                        phase_in = gfbc_pkg::PH_DONE;
                     end else begin
                        store_en   = 1'b1;
                        wp_in      = store_pos + 1'b1;
                        sampled_in = sampled_ff + 1'b1;
                        if (gap_ff) restart_in = restart_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         gfbc_pkg::CMD_START: begin
            max_in     = '0;
            min_in     = gfbc_pkg::ALL_ONES;
            wp_in      = '0;
            phase_in   = (mode_ff == gfbc_pkg::MODE_RESTART) ?
                         gfbc_pkg::PH_CAPTURE : gfbc_pkg::PH_SEEK;
            last_in    = item_ff.time_stamp;
            misfire_in = '0;
            restart_in = '0;
            if (mode_ff == gfbc_pkg::MODE_GAP_FINISH) sampled_in = '0;
         end
         default: begin
            // reads and the unused command leave the state alone
            wp_in = wp_ff;
         end
      endcase
   end

   // bit insert into the fetched word
   always_comb begin
      store_word = mem_rdata;
      store_word[store_pos[LSB-1:0]] = item_ff.data_bit;
   end

   // slice assembly from two adjacent words
   always_comb begin
      dword = {mem_rdata, word0_ff};
      raw   = 32'(dword >> item_ff.slice_from[LSB-1:0]);
      mask  = gfbc_pkg::ALL_ONES >> (5'd31 - span_ff);
      slice_val = raw & mask;
      if (item_ff.sign_extend && raw[span_ff]) begin
         slice_val = slice_val | ~mask;
      end
   end

   always_comb begin
      rsp_in               = '0;
      if (item_ff.command == gfbc_pkg::CMD_READ) begin
         rsp_in.slice_error = slice_err_ff;
         rsp_in.slice_value = slice_err_ff ? '0 : slice_val;
      end
      rsp_in.phase         = phase_in;
      rsp_in.bit_position  = wp_in;
      rsp_in.misfire_count = misfire_in;
      rsp_in.restart_count = restart_in;
      rsp_in.min_period    = min_in;
      rsp_in.max_period    = max_in;
      rsp_in.sampled_count = sampled_in;
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gfbc_pkg::ST_CLEAR;
         clr_ff         <= '0;
         mode_ff        <= gfbc_pkg::MODE_RESET;
         gap_period_ff  <= gfbc_pkg::ALL_ONES;
         bits_wanted_ff <= '0;
         wp_ff          <= '0;
         phase_ff       <= gfbc_pkg::PH_SEEK;
         last_ff        <= '0;
         min_ff         <= gfbc_pkg::ALL_ONES;
         max_ff         <= '0;
         misfire_ff     <= '0;
         restart_ff     <= '0;
         sampled_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == gfbc_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               gfbc_pkg::CSR_MODE:   mode_ff        <= csr_wdata[2:0];
               gfbc_pkg::CSR_GAP:    gap_period_ff  <= csr_wdata;
               gfbc_pkg::CSR_WANTED: bits_wanted_ff <= csr_wdata[12:0];
               default:              mode_ff        <= mode_ff;
            endcase
         end
         if (commit) begin
            wp_ff      <= wp_in;
            phase_ff   <= phase_in;
            last_ff    <= last_in;
            min_ff     <= min_in;
            max_ff     <= max_in;
            misfire_ff <= misfire_in;
            restart_ff <= restart_in;
            sampled_ff <= sampled_in;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff   <= req_payload;
         period_ff <= req_payload.time_stamp - last_ff;
      end
      if (state_ff == gfbc_pkg::ST_CALC) begin
         gap_ff        <= gap_now;
         store_zero_ff <= store_zero_now;
         slice_err_ff  <= slice_err_now;
         span_ff       <= slice_diff[4:0];
      end
      if (state_ff == gfbc_pkg::ST_FETCH2) begin
         word0_ff <= mem_rdata;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   gfbc_ram #(
      .WIDTH(gfbc_pkg::WORD_BITS),
      .DEPTH(gfbc_pkg::WORDS)
   ) u_bit_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

@@ rtl/gfbc_ram.sv @@
module gfbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/gfbc_checker.sv @@
`include "gap_framed_clocked_bit_capture_core_defines.svh"

module gfbc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input gfbc_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input gfbc_pkg::rsp_type rsp_payload
);

   logic req_take, slot_free;

   assign req_take  = req_valid && req_ready;
   assign slot_free = !rsp_valid || rsp_ready;

   // stalled result holds
   `GFBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp changed while stalled")

   // one item in flight at a time
   `GFBC_ASSERT_NEXT(a_one_item, req_take, !req_ready, "req_ready high right after an accept")

   // start with a free output slot: a result comes with cleared counters
   `GFBC_ASSERT_DELAY(a_start_rsp, req_take && slot_free && req_payload.command == gfbc_pkg::CMD_START, 3, rsp_valid && rsp_payload.misfire_count == '0 && rsp_payload.restart_count == '0 && !rsp_payload.slice_error && rsp_payload.slice_value == '0, "start result missing or wrong")

   // read with a free output slot: a result comes, and an error forces zero value
   `GFBC_ASSERT_DELAY(a_read_rsp, req_take && slot_free && req_payload.command == gfbc_pkg::CMD_READ, 4, rsp_valid && (!rsp_payload.slice_error || rsp_payload.slice_value == '0), "read result missing or wrong")

endmodule

bind gap_framed_clocked_bit_capture_core gfbc_checker u_gfbc_checker (.*);

@@ verif/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gfbc_pkg::*;

   // codes outside the documented ranges, still decoded by the block
   localparam logic [1:0] CMD_SPARE     = 2'd3;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   localparam int HOLD_CYCLES   = 400;  // long receiver stall for the pressure test
   localparam int SETTLE_CYCLES = 8;    // quiet time before a register write
   localparam int TAIL_CYCLES   = 20;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;
   logic          csr_we    = 1'b0;
   logic [1:0]    csr_index = CSR_MODE;
   logic [31:0]   csr_wdata = '0;

   // predictor copy of the capture state and registers
   logic              cap_bits [BUFFER_BITS];
   logic [POS_W-1:0]  wr_pos;
   logic [1:0]        cur_phase;
   logic [31:0]       last_edge;
   logic [31:0]       min_per;
   logic [31:0]       max_per;
   logic [31:0]       misfires;
   logic [31:0]       restarts;
   logic [15:0]       sampled_cnt;
   logic [2:0]        cfg_mode;
   logic [31:0]       cfg_gap;
   logic [12:0]       cfg_wanted;

   rsp_type     pending_snapshots [$];
   rsp_type     want_rsp;
   int          bad_results   = 0;
   int          items_sent    = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          holds_asked   = 0;
   int          holds_done    = 0;
   int          hold_left     = 0;
   logic [31:0] line_time     = '0;   // time stamp of the last edge or start sent

   gap_framed_clocked_bit_capture_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: applies one item to the local state, returns the snapshot
   // ---------------------------------------------------------------------
   function automatic void store_bit(logic din);
      cap_bits[wr_pos] = din;
      wr_pos = wr_pos + 1'b1;
   endfunction

   function automatic rsp_type predict_capture(req_type it);
      rsp_type     r;
      logic [31:0] period;
      logic        gap;
      logic        stamp;
      int          hi;
      int          lo;
      int          span;
      int          k;
      r = '0;
      case (it.command)
         CMD_EDGE: begin
            // modes 5..7 drop edges entirely
            if (cfg_mode <= MODE_GAP_FINISH) begin
               period = it.time_stamp - last_edge;
               gap    = period > cfg_gap;
               stamp  = 1'b1;
               if (cfg_mode == MODE_STATS) begin
                  if (period < min_per) min_per = period;
                  if (period > max_per) max_per = period;
               end else if (cur_phase == PH_DONE) begin
                  misfires = misfires + 1;
                  stamp    = 1'b0;
               end else begin
                  case (cfg_mode)
                     MODE_GAP_COUNT: begin
                        if (cur_phase == PH_SEEK) begin
                           if (gap) begin
                              cur_phase = PH_CAPTURE;
                              wr_pos    = wr_pos + 1'b1;
                           end
                        end else if (gap) begin
                           // closing gap: time stamp stays at the previous edge
                           cur_phase = PH_DONE;
                           stamp     = 1'b0;
                        end else begin
                           wr_pos = wr_pos + 1'b1;
                        end
                     end
                     MODE_RESTART, MODE_GAP_WAIT: begin
                        if (cfg_mode == MODE_GAP_WAIT && cur_phase == PH_SEEK) begin
                           if (gap) begin
                              cur_phase = PH_CAPTURE;
                              store_bit(it.data_bit);
                           end
                        end else begin
                           if (gap) begin
                              wr_pos   = '0;
                              restarts = restarts + 1;
                           end
                           store_bit(it.data_bit);
                           if (!gap && cfg_wanted <= {1'b0, wr_pos}) cur_phase = PH_DONE;
                        end
                     end
                     default: begin
                        if (gap && sampled_cnt >= {3'b0, cfg_wanted}) begin
                           cur_phase = PH_DONE;
                        end else begin
                           if (gap) begin
                              wr_pos   = '0;
                              restarts = restarts + 1;
                           end
                           store_bit(it.data_bit);
                           sampled_cnt = sampled_cnt + 1'b1;
                        end
                     end
                  endcase
               end
               if (stamp) last_edge = it.time_stamp;
            end
         end
         CMD_START: begin
            max_per   = '0;
            min_per   = ALL_ONES;
            wr_pos    = '0;
            cur_phase = (cfg_mode == MODE_RESTART) ? PH_CAPTURE : PH_SEEK;
            last_edge = it.time_stamp;
            misfires  = '0;
            restarts  = '0;
            if (cfg_mode == MODE_GAP_FINISH) sampled_cnt = '0;
         end
         CMD_READ: begin
            hi = int'(it.slice_to);
            lo = int'(it.slice_from);
            // nothing past the write position is readable
            if (hi >= int'(wr_pos)) hi = int'(wr_pos) - 1;
            if (lo > hi || hi - lo > 31) begin
               r.slice_error = 1'b1;
            end else begin
               span = hi - lo;
               for (k = 0; k <= span; k++) r.slice_value[k] = cap_bits[lo + k];
               if (it.sign_extend && r.slice_value[span])
                  r.slice_value = r.slice_value | (ALL_ONES << span);
            end
         end
         default: ;
      endcase
      r.phase         = cur_phase;
      r.bit_position  = wr_pos;
      r.misfire_count = misfires;
      r.restart_count = restarts;
      r.min_period    = min_per;
      r.max_period    = max_per;
      r.sampled_count = sampled_cnt;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------
   task automatic send_item(req_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_snapshots.push_back(predict_capture(it));
      if (!(it.command == CMD_EDGE && cfg_mode > MODE_GAP_FINISH)) items_sent++;
   endtask

   // unused fields of an item carry random values
   function automatic req_type random_req();
      req_type it;
      it.command     = CMD_EDGE;
      it.time_stamp  = $urandom;
      it.data_bit    = 1'($urandom_range(0, 1));
      it.slice_from  = POS_W'($urandom_range(0, BUFFER_BITS - 1));
      it.slice_to    = POS_W'($urandom_range(0, BUFFER_BITS - 1));
      it.sign_extend = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic send_edge(logic [31:0] period, logic din);
      req_type it;
      it            = random_req();
      line_time     = line_time + period;
      it.time_stamp = line_time;
      it.data_bit   = din;
      send_item(it);
   endtask

   task automatic send_start(logic [31:0] stamp_at);
      req_type it;
      it            = random_req();
      it.command    = CMD_START;
      it.time_stamp = stamp_at;
      line_time     = stamp_at;
      send_item(it);
   endtask

   task automatic send_read(int from, int upto, logic sext);
      req_type it;
      it             = random_req();
      it.command     = CMD_READ;
      it.slice_from  = POS_W'(from);
      it.slice_to    = POS_W'(upto);
      it.sign_extend = sext;
      send_item(it);
   endtask

   // slices mostly near written data, some fully random
   task automatic send_read_random();
      int from;
      int upto;
      if ($urandom_range(0, 5) == 0) begin
         from = $urandom_range(0, BUFFER_BITS - 1);
         upto = $urandom_range(0, BUFFER_BITS - 1);
      end else begin
         from = $urandom_range(0, wr_pos + 2);
         upto = from + $urandom_range(0, 35);
      end
      if (from > BUFFER_BITS - 1) from = BUFFER_BITS - 1;
      if (upto > BUFFER_BITS - 1) upto = BUFFER_BITS - 1;
      send_read(from, upto, 1'($urandom_range(0, 1)));
   endtask

   // period that is not a gap, boundary value included
   function automatic logic [31:0] short_period();
      case ($urandom_range(0, 7))
         0:       return cfg_gap;
         1:       return '0;
         default: return $urandom_range(0, (cfg_gap > 3000) ? 3000 : cfg_gap);
      endcase
   endfunction

   // period above gap_period; with gap_period at all ones there is none
   function automatic logic [31:0] long_period();
      if (cfg_gap == ALL_ONES) return $urandom;
      if ($urandom_range(0, 3) == 0) return cfg_gap + 1;
      return $urandom_range(cfg_gap + 1, ALL_ONES);
   endfunction

   // wait until the block has returned everything, then a few quiet cycles
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_snapshots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [1:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MODE:   cfg_mode   = value[2:0];
         CSR_GAP:    cfg_gap    = value;
         CSR_WANTED: cfg_wanted = value[12:0];
         default: ;
      endcase
   endtask

   task automatic write_regs(logic [2:0] mode, logic [31:0] gap, logic [12:0] wanted);
      settle();
      csr_put(CSR_MODE, {29'b0, mode});
      csr_put(CSR_GAP, gap);
      csr_put(CSR_WANTED, {19'b0, wanted});
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_corner_cases();
      // reset defaults: gap-wait mode, no gap possible, nothing written
      send_read(0, 31, 1'b1);
      send_item('{command: CMD_SPARE, time_stamp: ALL_ONES, data_bit: 1'b1,
                  slice_from: '1, slice_to: '1, sign_extend: 1'b1});
      send_edge(ALL_ONES, 1'b1);

      // gap-wait with gap_period 0: any nonzero period is a gap, stamps wrap
      write_regs(MODE_GAP_WAIT, '0, 13'd2);
      send_start(ALL_ONES - 1);
      send_edge(0, 1'b1);
      send_edge(5, 1'b1);
      send_edge(0, 1'b0);
      send_edge(9, 1'b1);           // after done: misfire
      send_read(0, 0, 1'b1);        // one set bit, sign extended
      send_read(4095, 4095, 1'b0);  // clamped below from

      // gap count: period equal to gap_period is not a gap
      write_regs(MODE_GAP_COUNT, 32'd10, '0);
      send_start(0);
      send_edge(11, 1'b0);
      send_edge(10, 1'b0);
      send_edge(11, 1'b0);          // second gap, time stamp kept
      send_edge(1, 1'b0);

      // restart capture, a count that the wrapping position never reaches
      write_regs(MODE_RESTART, 32'd10, 13'd4096);
      send_start(100);
      send_edge(2, 1'b1);
      send_edge(11, 1'b0);
      send_read(1, 0, 1'b0);        // from above to

      // gap-finish ends on a gap once enough bits are in
      write_regs(MODE_GAP_FINISH, 32'd10, 13'd1);
      send_start(0);
      send_edge(2, 1'b1);
      send_edge(11, 1'b0);

      // statistics with a wrapped period, then a spare mode
      write_regs(MODE_STATS, ALL_ONES, 13'd4095);
      send_start(5);
      send_edge(ALL_ONES, 1'b0);
      write_regs(MODE_SPARE_HI, '0, '0);
      send_start(ALL_ONES);         // acts as in statistics mode
      send_edge(7, 1'b1);           // ignored
   endtask

   // one frame per register setting: optional start, lead-in, opening gap,
   // body with a few restarts, reads, and now and then some noise
   task automatic test_random_frames(int count);
      int          first;
      int          n;
      int          i;
      logic [2:0]  mode;
      logic [31:0] gap;
      logic [12:0] wanted;
      req_type     it;
      first = items_sent;
      while (items_sent - first < count) begin
         n = $urandom_range(0, 99);
         if (n < 10) mode = MODE_STATS;
         else if (n < 14) mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         else mode = 3'($urandom_range(MODE_GAP_COUNT, MODE_GAP_FINISH));
         n = $urandom_range(0, 99);
         if (n < 8) gap = '0;
         else if (n < 14) gap = ALL_ONES;
         else if (n < 20) gap = $urandom;
         else gap = $urandom_range(4, 2000);
         n = $urandom_range(0, 99);
         if (n < 4) wanted = 13'd4096;
         else if (n < 8) wanted = 13'($urandom_range(0, 4096));
         else wanted = 13'($urandom_range(0, 40));
         write_regs(mode, gap, wanted);

         if ($urandom_range(0, 9) != 0) send_start($urandom);
         repeat ($urandom_range(0, 3)) send_edge(short_period(), 1'($urandom_range(0, 1)));
         send_edge(long_period(), 1'($urandom_range(0, 1)));
         n = ((wanted > 48) ? 48 : wanted) + $urandom_range(0, 4);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
               send_edge(long_period(), 1'($urandom_range(0, 1)));
            else
               send_edge(short_period(), 1'($urandom_range(0, 1)));
         end
         repeat ($urandom_range(1, 4)) send_read_random();

         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 5)) begin
               it = random_req();
               case ($urandom_range(0, 7))
                  0, 1, 2, 3: begin
                     line_time     = line_time +
                                     ($urandom_range(0, 1) ? short_period() : long_period());
                     it.time_stamp = line_time;
                  end
                  4, 5: it.command = CMD_READ;
                  6: begin
                     it.command = CMD_START;
                     line_time  = it.time_stamp;
                  end
                  default: it.command = CMD_SPARE;
               endcase
               send_item(it);
            end
            send_read_random();
         end
      end
   endtask

   // receiver stalls for a long stretch while items keep coming
   task automatic test_backpressure();
      int i;
      write_regs(MODE_GAP_WAIT, 32'd50, 13'd30);
      send_start($urandom);
      holds_asked++;
      send_edge(long_period(), 1'b1);
      for (i = 0; i < 40; i++) begin
         if (i % 4 == 3) send_read_random();
         else send_edge(short_period(), 1'($urandom_range(0, 1)));
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random ready, with an occasional long hold-off
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (holds_asked != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checking against the oldest prediction
   // ---------------------------------------------------------------------
   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         bad_results++;
      end
   endfunction

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (pending_snapshots.size() == 0) begin
               $error("result item with no prediction waiting");
               bad_results++;
            end else begin
               want_rsp = pending_snapshots.pop_front();
               compare_field("slice_value", want_rsp.slice_value, rsp_payload.slice_value);
               compare_field("slice_error", 32'(want_rsp.slice_error),
                             32'(rsp_payload.slice_error));
               compare_field("phase", 32'(want_rsp.phase), 32'(rsp_payload.phase));
               compare_field("bit_position", 32'(want_rsp.bit_position),
                             32'(rsp_payload.bit_position));
               compare_field("misfire_count", want_rsp.misfire_count,
                             rsp_payload.misfire_count);
               compare_field("restart_count", want_rsp.restart_count,
                             rsp_payload.restart_count);
               compare_field("min_period", want_rsp.min_period, rsp_payload.min_period);
               compare_field("max_period", want_rsp.max_period, rsp_payload.max_period);
               compare_field("sampled_count", 32'(want_rsp.sampled_count),
                             32'(rsp_payload.sampled_count));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      foreach (cap_bits[i]) cap_bits[i] = 1'b0;
      wr_pos      = '0;
      cur_phase   = PH_SEEK;
      last_edge   = '0;
      min_per     = ALL_ONES;
      max_per     = '0;
      misfires    = '0;
      restarts    = '0;
      sampled_cnt = '0;
      cfg_mode    = MODE_RESET;
      cfg_gap     = ALL_ONES;
      cfg_wanted  = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sender idles more lightly than the receiver
      send_idle_pct = 36;
      recv_idle_pct = 63;
      test_corner_cases();
      test_random_frames(420);

      // roles swapped
      send_idle_pct = 63;
      recv_idle_pct = 36;
      test_random_frames(420);

      // full rate, then the long stall
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(420);
      test_backpressure();

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_snapshots.size() != 0) begin
         $error("%0d predicted result items never arrived", pending_snapshots.size());
         bad_results++;
      end
      if (bad_results == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog, far beyond the slowest passing run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
